### hdl/dhcp_lease_table_engine_unit_macros.svh
// Assertion macros shared by the lease table engine.
`ifndef DHCP_LEASE_TABLE_ENGINE_UNIT_MACROS_SVH
`define DHCP_LEASE_TABLE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DLTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DLTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dlte_pkg.sv
// Shared types, codes and constants of the lease table engine.
package dlte_pkg;

    localparam int LEASE_SLOTS_DEF = 1024;
    localparam int CFG_IDX_W       = 3;
    localparam int IN_TDATA_W      = 216;
    localparam int OUT_TDATA_W     = 72;

    localparam logic [31:0] OFFER_HOLD_RST   = 32'd60;
    localparam logic [31:0] DECLINE_HOLD_RST = 32'd3600;
    localparam logic [31:0] MIN_LEASE_RST    = 32'd60;
    localparam logic [31:0] MAX_LEASE_RST    = 32'd864000;
    localparam logic [7:0]  HOST_BCAST       = 8'hff;
    localparam logic [7:0]  HOST_NET         = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFER_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINE_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEASE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE    = 3'd6;

    typedef enum logic [2:0] {
        REQ_DISCOVER = 3'd0,
        REQ_REQUEST  = 3'd1,
        REQ_DECLINE  = 3'd2,
        REQ_RELEASE  = 3'd3,
        REQ_INFORM   = 3'd4
    } req_type_t;

    typedef enum logic [2:0] {
        RPL_NONE   = 3'd0,
        RPL_OFFER  = 3'd1,
        RPL_ACK    = 3'd2,
        RPL_NAK    = 3'd3,
        RPL_INFORM = 3'd4
    } reply_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_DECIDE, ST_FADDR,
        ST_FSCAN, ST_FEND, ST_STORE, ST_VWRITE, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SW_CLEAR, SW_LOOK, SW_FIND, SW_STORE
    } sweep_mode_t;

    typedef enum logic [1:0] {
        TGT_LEASE, TGT_REQ, TGT_ADDR, TGT_BEST
    } tgt_sel_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] expiry;
    } slot_t;

    typedef struct packed {
        logic        load_in;
        logic        sweep_start;
        sweep_mode_t mode;
        logic        tgt_load;
        tgt_sel_t    tgt_sel;
        logic        addr_init;
        logic        addr_step;
        logic        reply_set;
        reply_kind_t reply_kind;
        logic        wr_decline;
        logic        wr_release;
        logic        wr_victim;
        logic        out_load;
    } cmd_t;

    typedef struct packed {
        logic       sweep_done;
        logic       find_hit;
        logic       drop;
        logic [2:0] req_type;
        logic       lease_hit;
        logic       lease_ip_zero;
        logic       req_ok;
        logic       want_zero;
        logic       want_match;
        logic       nak_ok;
        logic       decl_ok;
        logic       rel_ok;
        logic       addr_skip;
        logic       addr_last;
        logic       best_ok;
        logic       vic_hit;
        logic       out_free;
    } status_t;

endpackage

### hdl/dlte_ctrl.sv
// Sequencing state machine of the lease table engine.
module dlte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dlte_pkg::status_t stat,
    output dlte_pkg::cmd_t    cmd
);

    dlte_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dlte_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dlte_pkg::ST_CLEAR: begin
                if (stat.sweep_done) state_next = dlte_pkg::ST_IDLE;
            end
            dlte_pkg::ST_IDLE: begin
                if (in_valid) state_next = dlte_pkg::ST_LOOK;
            end
            dlte_pkg::ST_LOOK: begin
                if (stat.sweep_done) state_next = dlte_pkg::ST_DECIDE;
            end
            dlte_pkg::ST_DECIDE: begin
                state_next = dlte_pkg::ST_DONE;
                if (!stat.drop) begin
                    if (stat.req_type == dlte_pkg::REQ_DISCOVER) begin
                        if (stat.lease_hit) begin
                            if (!stat.lease_ip_zero) state_next = dlte_pkg::ST_STORE;
                        end else if (stat.req_ok) begin
                            state_next = dlte_pkg::ST_STORE;
                        end else begin
                            state_next = dlte_pkg::ST_FADDR;
                        end
                    end else if (stat.req_type == dlte_pkg::REQ_REQUEST) begin
                        if (!stat.want_zero && stat.want_match)
                            state_next = dlte_pkg::ST_STORE;
                    end
                end
            end
            dlte_pkg::ST_FADDR: begin
                if (!stat.addr_skip) state_next = dlte_pkg::ST_FSCAN;
                else if (stat.addr_last) state_next = dlte_pkg::ST_FEND;
            end
            dlte_pkg::ST_FSCAN: begin
                if (stat.sweep_done) begin
                    if (!stat.find_hit) state_next = dlte_pkg::ST_STORE;
                    else if (stat.addr_last) state_next = dlte_pkg::ST_FEND;
                    else state_next = dlte_pkg::ST_FADDR;
                end
            end
            dlte_pkg::ST_FEND: begin
                state_next = stat.best_ok ? dlte_pkg::ST_STORE : dlte_pkg::ST_DONE;
            end
            dlte_pkg::ST_STORE: begin
                if (stat.sweep_done) state_next = dlte_pkg::ST_VWRITE;
            end
            dlte_pkg::ST_VWRITE: begin
                state_next = dlte_pkg::ST_DONE;
            end
            dlte_pkg::ST_DONE: begin
                if (stat.out_free) state_next = dlte_pkg::ST_IDLE;
            end
            default: state_next = dlte_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.mode       = dlte_pkg::SW_LOOK;
        cmd.tgt_sel    = dlte_pkg::TGT_LEASE;
        cmd.reply_kind = dlte_pkg::RPL_NONE;
        in_ready       = (state_reg == dlte_pkg::ST_IDLE);

        cmd.load_in = (state_reg == dlte_pkg::ST_IDLE) && in_valid;

        if (state_next != state_reg) begin
            if (state_next == dlte_pkg::ST_LOOK) begin
                cmd.sweep_start = 1'b1;
                cmd.mode        = dlte_pkg::SW_LOOK;
            end else if (state_next == dlte_pkg::ST_FSCAN) begin
                cmd.sweep_start = 1'b1;
                cmd.mode        = dlte_pkg::SW_FIND;
            end else if (state_next == dlte_pkg::ST_STORE) begin
                cmd.sweep_start = 1'b1;
                cmd.mode        = dlte_pkg::SW_STORE;
                cmd.tgt_load    = 1'b1;
                if (state_reg == dlte_pkg::ST_FSCAN) begin
                    cmd.tgt_sel = dlte_pkg::TGT_ADDR;
                end else if (state_reg == dlte_pkg::ST_FEND) begin
                    cmd.tgt_sel = dlte_pkg::TGT_BEST;
                end else if (stat.req_type == dlte_pkg::REQ_DISCOVER && !stat.lease_hit) begin
                    cmd.tgt_sel = dlte_pkg::TGT_REQ;
                end
            end
        end

        unique case (state_reg)
            dlte_pkg::ST_DECIDE: begin
                cmd.addr_init = (state_next == dlte_pkg::ST_FADDR);
                if (!stat.drop) begin
                    if (stat.req_type == dlte_pkg::REQ_INFORM) begin
                        cmd.reply_set  = 1'b1;
                        cmd.reply_kind = dlte_pkg::RPL_INFORM;
                    end else if (stat.req_type == dlte_pkg::REQ_REQUEST && !stat.want_zero) begin
                        if (stat.want_match) begin
                            cmd.reply_set  = 1'b1;
                            cmd.reply_kind = dlte_pkg::RPL_ACK;
                        end else if (stat.nak_ok) begin
                            cmd.reply_set  = 1'b1;
                            cmd.reply_kind = dlte_pkg::RPL_NAK;
                        end
                    end
                    cmd.wr_decline = (stat.req_type == dlte_pkg::REQ_DECLINE) && stat.decl_ok;
                    cmd.wr_release = (stat.req_type == dlte_pkg::REQ_RELEASE) && stat.rel_ok;
                end
            end
            dlte_pkg::ST_FADDR: begin
                cmd.addr_step = stat.addr_skip;
            end
            dlte_pkg::ST_FSCAN: begin
                cmd.addr_step = stat.sweep_done && stat.find_hit;
            end
            dlte_pkg::ST_VWRITE: begin
                cmd.wr_victim = stat.vic_hit;
                if (stat.vic_hit && stat.req_type == dlte_pkg::REQ_DISCOVER) begin
                    cmd.reply_set  = 1'b1;
                    cmd.reply_kind = dlte_pkg::RPL_OFFER;
                end
            end
            dlte_pkg::ST_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/dlte_dpath.sv
// Lease table memory, sweep engine, config registers and reply register.
module dlte_dpath #(
    parameter int LEASE_SLOTS = dlte_pkg::LEASE_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [dlte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata,
    input  logic [dlte_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [2:0]                        s_tuser,
    input  dlte_pkg::cmd_t                    cmd,
    output dlte_pkg::status_t                 stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dlte_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                        m_tuser
);

    localparam int IW = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

    // config
    logic [31:0] own_ip_reg, first_reg, last_reg, offer_hold_reg;
    logic [31:0] decl_hold_reg, min_lease_reg, max_lease_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg     <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            offer_hold_reg <= dlte_pkg::OFFER_HOLD_RST;
            decl_hold_reg  <= dlte_pkg::DECLINE_HOLD_RST;
            min_lease_reg  <= dlte_pkg::MIN_LEASE_RST;
            max_lease_reg  <= dlte_pkg::MAX_LEASE_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                dlte_pkg::CFG_OWN_IP:       own_ip_reg     <= cfg_wdata;
                dlte_pkg::CFG_POOL_FIRST:   first_reg      <= cfg_wdata;
                dlte_pkg::CFG_POOL_LAST:    last_reg       <= cfg_wdata;
                dlte_pkg::CFG_OFFER_HOLD:   offer_hold_reg <= cfg_wdata;
                dlte_pkg::CFG_DECLINE_HOLD: decl_hold_reg  <= cfg_wdata;
                dlte_pkg::CFG_MIN_LEASE:    min_lease_reg  <= cfg_wdata;
                dlte_pkg::CFG_MAX_LEASE:    max_lease_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // request word
    logic [2:0]  type_reg;
    logic [47:0] mac_reg;
    logic [31:0] cip_reg, req_ip_reg, sid_reg, asked_reg, now_reg;
    logic        has_req_reg, has_sid_reg, has_lt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            type_reg    <= s_tuser;
            mac_reg     <= s_tdata[47:0];
            cip_reg     <= s_tdata[79:48];
            has_req_reg <= s_tdata[80];
            req_ip_reg  <= s_tdata[112:81];
            has_sid_reg <= s_tdata[113];
            sid_reg     <= s_tdata[145:114];
            has_lt_reg  <= s_tdata[146];
            asked_reg   <= s_tdata[178:147];
            now_reg     <= s_tdata[210:179];
        end
    end

    // table memory
    dlte_pkg::slot_t mem [LEASE_SLOTS];
    dlte_pkg::slot_t rdata_reg, wdata;
    logic            we;
    logic [IW-1:0]   waddr;

    // sweep
    logic                  issue_act_reg, rv_reg, rlast_reg;
    logic [IW-1:0]         iss_idx_reg, ridx_reg;
    dlte_pkg::sweep_mode_t mode_reg;
    logic                  iss_last, done_now, find_eq;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[iss_idx_reg];
    end

    assign iss_last = (iss_idx_reg == IW'(LEASE_SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_act_reg <= 1'b1;
            iss_idx_reg   <= '0;
            mode_reg      <= dlte_pkg::SW_CLEAR;
            rv_reg        <= 1'b0;
            rlast_reg     <= 1'b0;
            ridx_reg      <= '0;
        end else if (cmd.sweep_start) begin
            issue_act_reg <= 1'b1;
            iss_idx_reg   <= '0;
            mode_reg      <= cmd.mode;
            rv_reg        <= 1'b0;
        end else if (done_now) begin
            issue_act_reg <= 1'b0;
            rv_reg        <= 1'b0;
        end else begin
            rv_reg    <= issue_act_reg;
            ridx_reg  <= iss_idx_reg;
            rlast_reg <= iss_last;
            if (issue_act_reg) begin
                if (iss_last) issue_act_reg <= 1'b0;
                else iss_idx_reg <= iss_idx_reg + 1'b1;
            end
        end
    end

    // search state
    logic          mac_hit_reg, ip_hit_reg, best_valid_reg, vic_hit_reg;
    logic [IW-1:0] lease_idx_reg, vic_idx_reg;
    logic [31:0]   lease_ip_reg, ipj_exp_reg, best_exp_reg, best_ip_reg, vt_reg;
    logic [31:0]   addr_reg, tgt_reg, eff_exp;
    logic          store_clr;
    dlte_pkg::reply_kind_t kind_reg;

    assign find_eq   = rdata_reg.ip == addr_reg;
    assign done_now  = rv_reg && (rlast_reg || (mode_reg == dlte_pkg::SW_FIND && find_eq));
    assign store_clr = (rdata_reg.mac == mac_reg) ||
                       ((tgt_reg != '0) && (rdata_reg.ip == tgt_reg));
    assign eff_exp   = store_clr ? '0 : rdata_reg.expiry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_hit_reg    <= 1'b0;
            ip_hit_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            vic_hit_reg    <= 1'b0;
            kind_reg       <= dlte_pkg::RPL_NONE;
        end else begin
            if (cmd.load_in) kind_reg <= dlte_pkg::RPL_NONE;
            else if (cmd.reply_set) kind_reg <= cmd.reply_kind;

            if (cmd.sweep_start) begin
                if (cmd.mode == dlte_pkg::SW_LOOK) begin
                    mac_hit_reg <= 1'b0;
                    ip_hit_reg  <= 1'b0;
                end
                if (cmd.mode == dlte_pkg::SW_STORE) begin
                    vic_hit_reg <= 1'b0;
                    vt_reg      <= now_reg;
                end
            end else if (rv_reg) begin
                case (mode_reg)
                    dlte_pkg::SW_LOOK: begin
                        if (!mac_hit_reg && rdata_reg.mac == mac_reg) begin
                            mac_hit_reg   <= 1'b1;
                            lease_idx_reg <= ridx_reg;
                            lease_ip_reg  <= rdata_reg.ip;
                        end
                        if (!ip_hit_reg && rdata_reg.ip == req_ip_reg) begin
                            ip_hit_reg  <= 1'b1;
                            ipj_exp_reg <= rdata_reg.expiry;
                        end
                    end
                    dlte_pkg::SW_FIND: begin
                        if (find_eq && (!best_valid_reg || rdata_reg.expiry < best_exp_reg)) begin
                            best_valid_reg <= 1'b1;
                            best_exp_reg   <= rdata_reg.expiry;
                            best_ip_reg    <= rdata_reg.ip;
                        end
                    end
                    dlte_pkg::SW_STORE: begin
                        if (eff_exp == '0 || eff_exp < vt_reg) begin
                            vt_reg      <= eff_exp;
                            vic_idx_reg <= ridx_reg;
                            vic_hit_reg <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd.addr_init) best_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.addr_init) addr_reg <= first_reg;
        else if (cmd.addr_step) addr_reg <= addr_reg + 32'd1;

        if (cmd.tgt_load) begin
            case (cmd.tgt_sel)
                dlte_pkg::TGT_LEASE: tgt_reg <= lease_ip_reg;
                dlte_pkg::TGT_REQ:   tgt_reg <= req_ip_reg;
                dlte_pkg::TGT_ADDR:  tgt_reg <= addr_reg;
                default:             tgt_reg <= best_ip_reg;
            endcase
        end
    end

    // granted lease
    logic [31:0] lsec, clip, dur;
    always_comb begin
        clip = (asked_reg > max_lease_reg) ? max_lease_reg : asked_reg;
        if (clip < min_lease_reg) clip = min_lease_reg;
        lsec = has_lt_reg ? clip : max_lease_reg;
        dur  = (type_reg == dlte_pkg::REQ_DISCOVER) ? offer_hold_reg : lsec;
    end

    always_comb begin
        we    = 1'b0;
        waddr = ridx_reg;
        wdata = '0;
        if (rv_reg && mode_reg == dlte_pkg::SW_CLEAR) begin
            we = 1'b1;
        end else if (rv_reg && mode_reg == dlte_pkg::SW_STORE && store_clr) begin
            we = 1'b1;
        end else if (cmd.wr_decline) begin
            we           = 1'b1;
            waddr        = lease_idx_reg;
            wdata.ip     = lease_ip_reg;
            wdata.expiry = now_reg + decl_hold_reg;
        end else if (cmd.wr_release) begin
            we           = 1'b1;
            waddr        = lease_idx_reg;
            wdata.mac    = mac_reg;
            wdata.ip     = lease_ip_reg;
            wdata.expiry = now_reg;
        end else if (cmd.wr_victim) begin
            we           = 1'b1;
            waddr        = vic_idx_reg;
            wdata.mac    = mac_reg;
            wdata.ip     = tgt_reg;
            wdata.expiry = now_reg + dur;
        end
    end

    // output word
    logic        m_valid_reg, bcast_reg;
    logic [2:0]  okind_reg;
    logic [31:0] oip_reg, olease_reg;
    logic        grant;

    assign grant = (kind_reg == dlte_pkg::RPL_OFFER) || (kind_reg == dlte_pkg::RPL_ACK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            okind_reg  <= kind_reg;
            oip_reg    <= grant ? tgt_reg : '0;
            olease_reg <= grant ? lsec : '0;
            bcast_reg  <= (kind_reg == dlte_pkg::RPL_NAK);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {7'd0, bcast_reg, olease_reg, oip_reg};

    // status
    always_comb begin
        stat               = '0;
        stat.sweep_done    = done_now;
        stat.find_hit      = find_eq;
        stat.drop          = (has_sid_reg && sid_reg != own_ip_reg) ||
                             (type_reg > dlte_pkg::REQ_INFORM);
        stat.req_type      = type_reg;
        stat.lease_hit     = mac_hit_reg;
        stat.lease_ip_zero = (lease_ip_reg == '0);
        stat.req_ok        = has_req_reg && req_ip_reg != '0 && req_ip_reg >= first_reg &&
                             req_ip_reg <= last_reg && (!ip_hit_reg || ipj_exp_reg < now_reg);
        stat.want_zero     = !has_req_reg && cip_reg == '0;
        stat.want_match    = mac_hit_reg &&
                             ((has_req_reg ? req_ip_reg : cip_reg) == lease_ip_reg);
        stat.nak_ok        = has_sid_reg || has_req_reg;
        stat.decl_ok       = has_sid_reg && has_req_reg && mac_hit_reg &&
                             req_ip_reg == lease_ip_reg;
        stat.rel_ok        = has_sid_reg && mac_hit_reg && cip_reg == lease_ip_reg;
        stat.addr_skip     = addr_reg[7:0] == dlte_pkg::HOST_NET ||
                             addr_reg[7:0] == dlte_pkg::HOST_BCAST || addr_reg == own_ip_reg;
        stat.addr_last     = (addr_reg == last_reg);
        stat.best_ok       = best_valid_reg && best_exp_reg < now_reg;
        stat.vic_hit       = vic_hit_reg;
        stat.out_free      = !m_valid_reg || m_tready;
    end

endmodule

### hdl/dhcp_lease_table_engine_unit.sv
// DHCP lease table engine: top level.
//
// Input channel s_*: one pre-parsed client message per word, req_type on s_tuser.
// Output channel m_*: exactly one reply word per input word, reply_kind on m_tuser.
// Config channel cfg_*: register index and 32-bit value, always ready; write only
// while no request is in flight.
// After reset the table is swept to zero, with s_tready low.
// A request first scans the whole table, then:
//   inform, decline, release, nak, drop: no further scan, on to the output register;
//   offer or ack: a second table scan for clearing and victim choice;
//   discover without lease or valid requested address: one table scan per pool
//   address tried (ends early at a match), plus the final store scan.
// Each scan is set by the single read port of the lease memory, one slot a cycle.
// One request is worked at a time; the next is taken as soon as the previous
// reply sits in the output register, even if m_tready is low. A stalled
// receiver holds the finished reply and blocks the next one at its end only.
`include "dhcp_lease_table_engine_unit_macros.svh"
module dhcp_lease_table_engine_unit #(
    parameter int LEASE_SLOTS = dlte_pkg::LEASE_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // client_mac, client_ip, has_req_addr, req_addr, has_srv_ident,
    // srv_ident, has_lease_time, asked_lease_sec, now_sec, zero fill
    input  logic [dlte_pkg::IN_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // your_ip, lease_sec, bcast_flag, zero fill
    output logic [dlte_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // reply_kind
    output logic [2:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata
);

    dlte_pkg::cmd_t    cmd;
    dlte_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    dlte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dlte_dpath #(
        .LEASE_SLOTS (LEASE_SLOTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `DLTE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    `DLTE_ASSERT_NOW(a_nak_bcast, m_tvalid && m_tuser == dlte_pkg::RPL_NAK, m_tdata[64], "nak without broadcast")
    `DLTE_ASSERT_NOW(a_no_grant_zero, m_tvalid && m_tuser != dlte_pkg::RPL_OFFER && m_tuser != dlte_pkg::RPL_ACK, m_tdata[63:0] == 64'd0, "address or lease on a non-grant reply")

endmodule

### tb/dhcp_lease_table_engine_unit_tb.sv
// Self-checking testbench for the DHCP lease table engine.
`timescale 1ns / 100ps
module dhcp_lease_table_engine_unit_tb;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [31:0] ciaddr;
        logic        has_req;
        logic [31:0] req_ip;
        logic        has_sid;
        logic [31:0] sid;
        logic        has_lt;
        logic [31:0] asked;
        logic [31:0] now;
        bit          fill_ip;
    } dhcp_msg_t;

    typedef struct {
        dlte_pkg::reply_kind_t kind;
        logic [31:0] ip;
        logic [31:0] lsec;
        logic        bcast;
    } dhcp_reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dlte_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic [2:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dlte_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [dlte_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    dhcp_lease_table_engine_unit #(.LEASE_SLOTS(NSLOT)) DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // lease table and registers as the engine should hold them
    logic [47:0] t_mac[NSLOT];
    logic [31:0] t_ip[NSLOT];
    logic [31:0] t_exp[NSLOT];
    logic [31:0] r_own, r_first, r_last, r_ohold, r_dhold, r_min, r_max;

    dhcp_msg_t   msg_q[$];
    dhcp_reply_t reply_q[$];
    dhcp_msg_t   cur_msg;
    int errs = 0;
    bit calm = 1'b0;
    bit long_go = 1'b0;
    logic [31:0] tnow = 32'd1000;
    logic [47:0] macs[8];

    function automatic int mac_slot(logic [47:0] m);
        for (int i = 0; i < NSLOT; i++)
            if (t_mac[i] == m) return i;
        return -1;
    endfunction

    function automatic int ip_slot(logic [31:0] a);
        for (int i = 0; i < NSLOT; i++)
            if (t_ip[i] == a) return i;
        return -1;
    endfunction

    function automatic logic [31:0] grant_time(logic has, logic [31:0] asked);
        logic [31:0] t;
        t = r_max;
        if (has) begin
            t = asked;
            if (t > r_max) t = r_max;
            if (t < r_min) t = r_min;
        end
        return t;
    endfunction

    function automatic int place_lease(logic [47:0] m, logic [31:0] a,
                                       logic [31:0] dur, logic [31:0] now);
        int best;
        logic [31:0] t;
        best = -1;
        t = now;
        for (int i = 0; i < NSLOT; i++)
            if (t_mac[i] == m || (a != 0 && t_ip[i] == a)) begin
                t_mac[i] = '0;
                t_ip[i] = '0;
                t_exp[i] = '0;
            end
        for (int i = 0; i < NSLOT; i++)
            if (t_exp[i] == 0 || t_exp[i] < t) begin
                t = t_exp[i];
                best = i;
            end
        if (best >= 0) begin
            t_mac[best] = m;
            t_ip[best] = a;
            t_exp[best] = now + dur;
        end
        return best;
    endfunction

    function automatic logic [31:0] pool_pick(logic [31:0] now);
        logic [31:0] a, stop;
        int best, j;
        a = r_first;
        stop = r_last + 32'd1;
        best = -1;
        do begin
            if (a[7:0] != dlte_pkg::HOST_NET && a[7:0] != dlte_pkg::HOST_BCAST &&
                a != r_own) begin
                j = ip_slot(a);
                if (j < 0) return a;
                if (best < 0 || t_exp[j] < t_exp[best]) best = j;
            end
            a = a + 32'd1;
        end while (a != stop);
        if (best >= 0 && t_exp[best] < now) return t_ip[best];
        return '0;
    endfunction

    function automatic dhcp_reply_t reply_for(dhcp_msg_t q);
        dhcp_reply_t r;
        int ls, j;
        logic [31:0] a, want;
        bit ok;
        r.kind = dlte_pkg::RPL_NONE;
        r.ip = '0;
        r.lsec = '0;
        r.bcast = 1'b0;
        if (q.has_sid && q.sid != r_own) return r;
        ls = mac_slot(q.mac);
        case (q.kind)
            dlte_pkg::REQ_DISCOVER: begin
                if (ls >= 0) a = t_ip[ls];
                else begin
                    ok = q.has_req && q.req_ip != 0 && q.req_ip >= r_first
                         && q.req_ip <= r_last;
                    if (ok) begin
                        j = ip_slot(q.req_ip);
                        ok = (j < 0) || (t_exp[j] < q.now);
                    end
                    a = ok ? q.req_ip : pool_pick(q.now);
                end
                if (a != 0 && place_lease(q.mac, a, r_ohold, q.now) >= 0) begin
                    r.kind = dlte_pkg::RPL_OFFER;
                    r.ip = a;
                    r.lsec = grant_time(q.has_lt, q.asked);
                end
            end
            dlte_pkg::REQ_REQUEST: begin
                want = q.has_req ? q.req_ip : q.ciaddr;
                if (q.has_req || want != 0) begin
                    if (ls >= 0 && want == t_ip[ls]) begin
                        r.kind = dlte_pkg::RPL_ACK;
                        r.ip = t_ip[ls];
                        r.lsec = grant_time(q.has_lt, q.asked);
                        void'(place_lease(q.mac, r.ip, r.lsec, q.now));
                    end else if (q.has_sid || q.has_req) begin
                        r.kind = dlte_pkg::RPL_NAK;
                        r.bcast = 1'b1;
                    end
                end
            end
            dlte_pkg::REQ_DECLINE: begin
                if (q.has_sid && q.has_req && ls >= 0 && q.req_ip == t_ip[ls]) begin
                    t_mac[ls] = '0;
                    t_exp[ls] = q.now + r_dhold;
                end
            end
            dlte_pkg::REQ_RELEASE: begin
                if (q.has_sid && ls >= 0 && q.ciaddr == t_ip[ls]) t_exp[ls] = q.now;
            end
            dlte_pkg::REQ_INFORM: r.kind = dlte_pkg::RPL_INFORM;
            default: ;
        endcase
        return r;
    endfunction

    // request word generator; noise draws every field at full width
    function automatic dhcp_msg_t make_msg(bit noise);
        dhcp_msg_t q;
        int p;
        q.mac = macs[$urandom_range(0, 7)];
        q.has_req = $urandom_range(0, 3) != 0;
        q.req_ip = r_first + $urandom_range(0, r_last - r_first);
        q.has_sid = 1'($urandom_range(0, 1));
        q.sid = ($urandom_range(0, 9) == 0) ? $urandom : r_own;
        q.has_lt = 1'($urandom_range(0, 1));
        q.asked = $urandom_range(0, 1) ? $urandom_range(0, 9000) : $urandom;
        q.ciaddr = $urandom_range(0, 1) ? 32'd0 : q.req_ip;
        q.fill_ip = $urandom_range(0, 2) != 0;
        tnow = tnow + (($urandom_range(0, 15) == 0) ? 32'd100000 : $urandom_range(0, 60));
        q.now = tnow;
        p = $urandom_range(0, 99);
        q.kind = p < 35 ? dlte_pkg::REQ_DISCOVER : p < 72 ? dlte_pkg::REQ_REQUEST :
                 p < 82 ? dlte_pkg::REQ_DECLINE : p < 92 ? dlte_pkg::REQ_RELEASE :
                 dlte_pkg::REQ_INFORM;
        if (noise) begin
            q.kind = 3'($urandom_range(0, 7));
            q.mac = 48'({$urandom, $urandom});
            q.ciaddr = $urandom;
            q.req_ip = $urandom;
            q.sid = $urandom;
            q.asked = $urandom;
            q.now = $urandom;
            q.fill_ip = 1'b0;
        end
        return q;
    endfunction

    function automatic dhcp_msg_t direct(logic [2:0] k, logic [47:0] m, logic hr,
                                         logic [31:0] rip, logic hs, logic [31:0] sid,
                                         logic [31:0] ci, logic [31:0] now);
        dhcp_msg_t q;
        q.kind = k;
        q.mac = m;
        q.ciaddr = ci;
        q.has_req = hr;
        q.req_ip = rip;
        q.has_sid = hs;
        q.sid = sid;
        q.has_lt = 1'b1;
        q.asked = $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
        q.now = now;
        q.fill_ip = 1'b0;
        return q;
    endfunction

    // input driver
    int src_gap = 0;
    always @(posedge aclk) begin
        dhcp_reply_t r;
        int j;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                r = reply_for(cur_msg);
                reply_q.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (msg_q.size() > 0) begin
                    cur_msg = msg_q.pop_front();
                    if (cur_msg.fill_ip) begin
                        j = mac_slot(cur_msg.mac);
                        if (j >= 0) begin
                            cur_msg.req_ip = t_ip[j];
                            if (cur_msg.ciaddr != 0) cur_msg.ciaddr = t_ip[j];
                        end
                    end
                    s_tdata <= {5'd0, cur_msg.now, cur_msg.asked, cur_msg.has_lt,
                                cur_msg.sid, cur_msg.has_sid, cur_msg.req_ip,
                                cur_msg.has_req, cur_msg.ciaddr, cur_msg.mac};
                    s_tuser <= cur_msg.kind;
                    s_tvalid <= 1'b1;
                    src_gap <= calm ? 0 : $urandom_range(0, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor and receiver stalls
    int snk_stall = 0;
    bit long_done = 1'b0;
    always @(posedge aclk) begin
        dhcp_reply_t e;
        int nst;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_stall <= 0;
        end else begin
            nst = (snk_stall > 0) ? snk_stall - 1 : 0;
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("reply word with nothing expected");
                    errs++;
                end else begin
                    e = reply_q.pop_front();
                    if (m_tuser !== e.kind) begin
                        $error("reply_kind exp %0d got %0d", e.kind, m_tuser);
                        errs++;
                    end
                    if (m_tdata[31:0] !== e.ip) begin
                        $error("your_ip exp %h got %h", e.ip, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[63:32] !== e.lsec) begin
                        $error("lease_sec exp %0d got %0d", e.lsec, m_tdata[63:32]);
                        errs++;
                    end
                    if (m_tdata[64] !== e.bcast) begin
                        $error("bcast_flag exp %0d got %0d", e.bcast, m_tdata[64]);
                        errs++;
                    end
                end
                nst = calm ? 0 : $urandom_range(0, 17);
                if (long_go && !long_done) begin
                    nst = 400;
                    long_done <= 1'b1;
                end
            end
            snk_stall <= nst;
            m_tready <= (nst == 0);
        end
    end

    // register file as written
    always @(posedge aclk) begin
        if (!aresetn) begin
            r_own = '0; r_first = '0; r_last = '0;
            r_ohold = dlte_pkg::OFFER_HOLD_RST; r_dhold = dlte_pkg::DECLINE_HOLD_RST;
            r_min = dlte_pkg::MIN_LEASE_RST; r_max = dlte_pkg::MAX_LEASE_RST;
            for (int i = 0; i < NSLOT; i++) begin
                t_mac[i] = '0; t_ip[i] = '0; t_exp[i] = '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dlte_pkg::CFG_OWN_IP:       r_own = cfg_wdata;
                dlte_pkg::CFG_POOL_FIRST:   r_first = cfg_wdata;
                dlte_pkg::CFG_POOL_LAST:    r_last = cfg_wdata;
                dlte_pkg::CFG_OFFER_HOLD:   r_ohold = cfg_wdata;
                dlte_pkg::CFG_DECLINE_HOLD: r_dhold = cfg_wdata;
                dlte_pkg::CFG_MIN_LEASE:    r_min = cfg_wdata;
                dlte_pkg::CFG_MAX_LEASE:    r_max = cfg_wdata;
                default: ;
            endcase
        end
    end

    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[dhcp_lease_table_engine_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [dlte_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] own, logic [31:0] first, logic [31:0] last,
                            logic [31:0] oh, logic [31:0] dh, logic [31:0] mn,
                            logic [31:0] mx);
        write_reg(dlte_pkg::CFG_OWN_IP, own);
        write_reg(dlte_pkg::CFG_POOL_FIRST, first);
        write_reg(dlte_pkg::CFG_POOL_LAST, last);
        write_reg(dlte_pkg::CFG_OFFER_HOLD, oh);
        write_reg(dlte_pkg::CFG_DECLINE_HOLD, dh);
        write_reg(dlte_pkg::CFG_MIN_LEASE, mn);
        write_reg(dlte_pkg::CFG_MAX_LEASE, mx);
        @(posedge aclk);
    endtask

    // look only after the edge has settled
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (msg_q.size() > 0 || s_tvalid || reply_q.size() > 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) msg_q.push_back(make_msg($urandom_range(0, 9) == 0));
    endtask

    initial begin
        macs[0] = 48'h0;
        macs[1] = 48'hffffffffffff;
        for (int i = 2; i < 8; i++) macs[i] = {16'h0200, 24'h0, i[7:0]};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: empty pool, so discover finds nothing
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[2], 0, 0, 0, 0, 0, 32'd5));
        msg_q.push_back(direct(dlte_pkg::REQ_INFORM, macs[2], 0, 0, 0, 0, 0, 32'd5));
        msg_q.push_back(direct(3'd7, macs[2], 0, 0, 0, 0, 0, 32'd5));
        drain();

        set_regs(32'h0a000001, 32'h0a000000, 32'h0a00000c, 32'd60, 32'd3600,
                 32'd100, 32'd5000);
        // offer/ack, nak, wrong server id, decline, release, zero MAC, full pool
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[2], 0, 0, 0, 0, 0, 32'd100));
        msg_q.push_back(direct(dlte_pkg::REQ_REQUEST, macs[2], 1, 32'h0a000002, 1,
                               32'h0a000001, 0, 32'd101));
        msg_q.push_back(direct(dlte_pkg::REQ_REQUEST, macs[2], 0, 0, 0, 0,
                               32'h0a000002, 32'd102));
        msg_q.push_back(direct(dlte_pkg::REQ_REQUEST, macs[3], 1, 32'h0a000005, 0, 0, 0,
                               32'd103));
        msg_q.push_back(direct(dlte_pkg::REQ_REQUEST, macs[3], 0, 0, 0, 0, 0, 32'd103));
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[3], 1, 32'h0a000007, 1,
                               32'hdeadbeef, 0, 32'd104));
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[3], 1, 32'h0a000007, 1,
                               32'h0a000001, 0, 32'd104));
        msg_q.push_back(direct(dlte_pkg::REQ_DECLINE, macs[3], 1, 32'h0a000007, 1,
                               32'h0a000001, 0, 32'd105));
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[0], 0, 0, 0, 0, 0, 32'd106));
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[1], 1, 32'h0a0000ff, 0, 0, 0,
                               32'd107));
        msg_q.push_back(direct(dlte_pkg::REQ_RELEASE, macs[2], 0, 0, 1, 32'h0a000001,
                               32'h0a000002, 32'd108));
        for (int i = 4; i < 16; i++)
            msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, {40'h1, i[7:0]}, 0, 0, 0, 0, 0,
                                   32'd110));
        msg_q.push_back(direct(dlte_pkg::REQ_DISCOVER, macs[7], 0, 0, 0, 0, 0,
                               32'hffffffff));
        drain();
        calm = 1'b1;
        random_run(10);
        drain();
        calm = 1'b0;
        random_run(20);
        drain();

        // wrapping pool, expiry sums that wrap, minimum above maximum
        set_regs(32'hffffffff, 32'hfffffffe, 32'h00000005, 32'hffffffff, 32'd0,
                 32'hffffffff, 32'd0);
        random_run(15);
        drain();

        // pool across a .255/.0 boundary, receiver held off while the sender fills it
        set_regs(32'd0, 32'hc0a801f8, 32'hc0a80205, 32'd0, 32'hffffffff, 32'd0,
                 32'hffffffff);
        long_go = 1'b1;
        random_run(25);
        drain();

        repeat (50) @(posedge aclk);
        if (reply_q.size() != 0) errs++;
        if (errs == 0) $display("[dhcp_lease_table_engine_unit] OK");
        else $display("[dhcp_lease_table_engine_unit] ERROR");
        $finish;
    end
endmodule
